>>> rtl/kot_pkg.sv
// ----------------------------------------------------------------------------
// kot_pkg
// shared types, token codes and character helpers for the tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package kot_pkg;

	// defaults for the top level parameters
	localparam int MAX_TOKEN_LEN_DEF = 63;
	localparam int POS_BITS_DEF      = 16;

	// candidate result slots per byte, results actually possible per byte
	localparam int NCAND      = 4;
	localparam int MAX_RES    = 3;
	localparam int NAME_BYTES = 8;

	// result queue, power of two deep
	localparam int Q_DEPTH = 4;

	// token type codes
	localparam logic [4:0] TT_EOF      = 5'd0;
	localparam logic [4:0] TT_NUM      = 5'd1;
	localparam logic [4:0] TT_NAME     = 5'd2;
	localparam logic [4:0] TT_PRINT    = 5'd3;
	localparam logic [4:0] TT_IF       = 5'd4;
	localparam logic [4:0] TT_ELSE     = 5'd5;
	localparam logic [4:0] TT_END      = 5'd6;
	localparam logic [4:0] TT_THEN     = 5'd7;
	localparam logic [4:0] TT_FUNCTION = 5'd8;
	localparam logic [4:0] TT_RETURN   = 5'd9;
	localparam logic [4:0] TT_PLUS     = 5'd10;
	localparam logic [4:0] TT_MINUS    = 5'd11;
	localparam logic [4:0] TT_STAR     = 5'd12;
	localparam logic [4:0] TT_SLASH    = 5'd13;
	localparam logic [4:0] TT_LPAREN   = 5'd14;
	localparam logic [4:0] TT_RPAREN   = 5'd15;
	localparam logic [4:0] TT_ASSIGN   = 5'd16;
	localparam logic [4:0] TT_EQEQ     = 5'd17;
	localparam logic [4:0] TT_NE       = 5'd18;
	localparam logic [4:0] TT_GT       = 5'd19;
	localparam logic [4:0] TT_LT       = 5'd20;
	localparam logic [4:0] TT_UNKNOWN  = 5'd21;

	// characters with a role of their own
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_EQ   = 8'h3D;

	// keywords, first byte in the low bits
	localparam logic [63:0] KW_PRINT    = 64'h0000_0074_6E69_7270;
	localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_ELSE     = 64'h0000_0000_6573_6C65;
	localparam logic [63:0] KW_END      = 64'h0000_0000_0064_6E65;
	localparam logic [63:0] KW_THEN     = 64'h0000_0000_6E65_6874;
	localparam logic [63:0] KW_FUNCTION = 64'h6E6F_6974_636E_7566;
	localparam logic [63:0] KW_RETURN   = 64'h0000_6E72_7574_6572;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_NAME,
		MODE_EQ,
		MODE_BANG
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_final;
	} tok_in_t;

	typedef struct packed {
		logic [4:0]  token_type;
		logic [15:0] start_pos;
		logic [5:0]  tok_len;
		logic        too_long;
		logic        run_end;
	} tok_out_t;

	typedef struct packed {
		logic     vld;
		tok_out_t tok;
	} cand_t;

	typedef cand_t [NCAND-1:0] cand_vec_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// single byte operators, anything else is unknown
	function automatic logic [4:0] op_type(logic [7:0] c);
		logic [4:0] t;
		case (c)
			8'h2B: t = TT_PLUS;
			8'h2D: t = TT_MINUS;
			8'h2A: t = TT_STAR;
			8'h2F: t = TT_SLASH;
			8'h28: t = TT_LPAREN;
			8'h29: t = TT_RPAREN;
			8'h3E: t = TT_GT;
			8'h3C: t = TT_LT;
			default: t = TT_UNKNOWN;
		endcase
		return t;
	endfunction

	// short_ok: at most eight bytes and not saturated
	function automatic logic [4:0] classify_name(logic short_ok, logic [3:0] len,
			logic [63:0] name);
		logic [4:0] t;
		t = TT_NAME;
		if (short_ok) begin
			if (len == 4'd5 && name == KW_PRINT) t = TT_PRINT;
			if (len == 4'd2 && name == KW_IF) t = TT_IF;
			if (len == 4'd4 && name == KW_ELSE) t = TT_ELSE;
			if (len == 4'd3 && name == KW_END) t = TT_END;
			if (len == 4'd4 && name == KW_THEN) t = TT_THEN;
			if (len == 4'd8 && name == KW_FUNCTION) t = TT_FUNCTION;
			if (len == 4'd6 && name == KW_RETURN) t = TT_RETURN;
		end
		return t;
	endfunction

	function automatic tok_out_t mk_tok(logic [4:0] tt, logic [15:0] start,
			logic [5:0] len, logic ovf);
		tok_out_t t;
		t.token_type = tt;
		t.start_pos  = start;
		t.tok_len    = len;
		t.too_long   = ovf;
		t.run_end    = 1'b0;
		return t;
	endfunction

	// token closed by whatever follows it
	function automatic tok_out_t flush_tok(scan_mode_t mode, logic [15:0] start,
			logic [5:0] len, logic ovf, logic short_ok, logic [3:0] len4,
			logic [63:0] name);
		tok_out_t t;
		case (mode)
			MODE_NUM:  t = mk_tok(TT_NUM, start, len, ovf);
			MODE_NAME: t = mk_tok(classify_name(short_ok, len4, name), start, len, ovf);
			MODE_EQ:   t = mk_tok(TT_ASSIGN, start, 6'd1, 1'b0);
			MODE_BANG: t = mk_tok(TT_UNKNOWN, start, 6'd1, 1'b0);
			default:   t = mk_tok(TT_EOF, start, 6'd0, 1'b0);
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

>>> rtl/keyword_operator_tokenizer.sv
// ----------------------------------------------------------------------------
// keyword_operator_tokenizer
// streaming tokenizer: source bytes in, typed tokens with offset and length out
// ----------------------------------------------------------------------------
// The block takes one source byte per transaction and can take a new byte in
// every cycle while src_ready is high. Each byte is decided in the cycle it is
// accepted: it may extend the open token, close it, start a new one, or produce
// a one-byte operator or end token, giving zero to three tokens. Those tokens
// are registered into a four-entry result queue and leave one per cycle while
// tok_ready is high. The source side keeps flowing while the queue holds at
// most one token, so with tok_ready held high a steady stream that yields a
// token per byte, or fewer, runs at one byte per cycle; bytes that yield two or
// three are paced by the single output port. A zero byte, or a byte flagged
// final, ends the text with an end token and the next byte starts at offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_operator_tokenizer import kot_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int POS_BITS      = POS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	// source bytes
	input  logic     src_valid,
	output logic     src_ready,
	input  tok_in_t  src_data,
	// tokens
	output logic     tok_valid,
	input  logic     tok_ready,
	output tok_out_t tok_data
);

	logic      take;
	cand_vec_t cands;

	// a byte is taken whenever the queue has room for its worst case
	assign take = src_valid && src_ready;

	// scan state and per-byte decision
	kot_scan #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.POS_BITS     (POS_BITS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (src_data),
		.cands (cands)
	);

	// result queue decouples token output from byte input
	kot_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (take),
		.cands    (cands),
		.space_ok (src_ready),
		.out_valid(tok_valid),
		.out_ready(tok_ready),
		.out_data (tok_data)
	);

endmodule

`default_nettype wire

>>> rtl/kot_scan.sv
// ----------------------------------------------------------------------------
// kot_scan
// scan state and per-byte token decision, up to four candidate slots a byte
// ----------------------------------------------------------------------------
`default_nettype none

module kot_scan import kot_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int POS_BITS      = POS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  tok_in_t   item,
	output cand_vec_t cands
);

	localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

	scan_mode_t          mode_q, mode_n;
	logic [POS_BITS-1:0] start_q, start_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic                ovf_q, ovf_n;
	logic [63:0]         name_q, name_n;
	logic [POS_BITS-1:0] pos_q, pos_n;

	logic                c_digit, c_alpha, c_space;
	logic                ext, beg, ended, old_short, new_short;
	logic [POS_BITS-1:0] pos_inc;
	logic [NCAND-1:0]    cvld;

	assign c_digit = is_digit(item.ch);
	assign c_alpha = is_alpha(item.ch);
	assign c_space = is_space(item.ch);
	assign pos_inc = pos_q + POS_BITS'(1);
	assign old_short = !ovf_q && (cnt_q <= CNT_W'(NAME_BYTES));
	assign new_short = !ovf_n && (cnt_n <= CNT_W'(NAME_BYTES));

	always_comb begin
		cands   = '0;
		mode_n  = mode_q;
		start_n = start_q;
		cnt_n   = cnt_q;
		ovf_n   = ovf_q;
		name_n  = name_q;
		pos_n   = pos_q;
		ext     = 1'b0;
		beg     = 1'b0;
		ended   = 1'b0;

		if ((mode_q == MODE_NUM && c_digit) ||
			(mode_q == MODE_NAME && (c_alpha || c_digit))) begin
			ext = 1'b1;
		end else if ((mode_q == MODE_EQ || mode_q == MODE_BANG) && item.ch == CH_EQ) begin
			// two byte operator
			cands[0].vld = 1'b1;
			cands[0].tok = mk_tok((mode_q == MODE_EQ) ? TT_EQEQ : TT_NE,
				16'(start_q), 6'd2, 1'b0);
			mode_n = MODE_IDLE;
		end else begin
			// close pending token, then look at the byte on its own
			cands[0].vld = (mode_q != MODE_IDLE);
			cands[0].tok = flush_tok(mode_q, 16'(start_q), 6'(cnt_q), ovf_q,
				old_short, 4'(cnt_q), name_q);
			mode_n = MODE_IDLE;
			if (item.ch == CH_NUL) begin
				cands[1].vld = 1'b1;
				cands[1].tok = mk_tok(TT_EOF, 16'(pos_q), 6'd0, 1'b0);
				ended = 1'b1;
			end else if (c_space) begin
				mode_n = MODE_IDLE;
			end else if (c_digit) begin
				beg    = 1'b1;
				mode_n = MODE_NUM;
			end else if (c_alpha) begin
				beg    = 1'b1;
				mode_n = MODE_NAME;
			end else if (item.ch == CH_EQ) begin
				beg    = 1'b1;
				mode_n = MODE_EQ;
			end else if (item.ch == CH_BANG) begin
				beg    = 1'b1;
				mode_n = MODE_BANG;
			end else begin
				cands[1].vld = 1'b1;
				cands[1].tok = mk_tok(op_type(item.ch), 16'(pos_q), 6'd1, 1'b0);
			end
		end

		// new token starts here
		if (beg) begin
			start_n = pos_q;
			cnt_n   = '0;
			ovf_n   = 1'b0;
			name_n  = '0;
		end

		// append the byte, keep first eight bytes, saturate the count
		if (ext || beg) begin
			if (cnt_n < CNT_W'(NAME_BYTES))
				name_n = name_n | (64'(item.ch) << {cnt_n[2:0], 3'b000});
			if (cnt_n < CNT_W'(MAX_TOKEN_LEN))
				cnt_n = cnt_n + CNT_W'(1);
			else
				ovf_n = 1'b1;
		end

		if (!ended) begin
			pos_n = pos_inc;
			if (item.is_final) begin
				cands[2].vld = (mode_n != MODE_IDLE);
				cands[2].tok = flush_tok(mode_n, 16'(start_n), 6'(cnt_n), ovf_n,
					new_short, 4'(cnt_n), name_n);
				cands[3].vld = 1'b1;
				cands[3].tok = mk_tok(TT_EOF, 16'(pos_inc), 6'd0, 1'b0);
				ended = 1'b1;
			end
		end

		// end of text, next byte begins a fresh text at offset zero
		if (ended) begin
			mode_n  = MODE_IDLE;
			start_n = '0;
			cnt_n   = '0;
			ovf_n   = 1'b0;
			name_n  = '0;
			pos_n   = '0;
		end

		// mark the last result of this byte
		if (cands[3].vld)
			cands[3].tok.run_end = 1'b1;
		else if (cands[1].vld)
			cands[1].tok.run_end = 1'b1;
		else if (cands[0].vld)
			cands[0].tok.run_end = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			name_q  <= '0;
			pos_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			cnt_q   <= cnt_n;
			ovf_q   <= ovf_n;
			name_q  <= name_n;
			pos_q   <= pos_n;
		end
	end

	always_comb begin
		for (int i = 0; i < NCAND; i++)
			cvld[i] = cands[i].vld;
	end

	a_text_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (item.ch == CH_NUL || item.is_final)) |=>
		(pos_q == '0 && mode_q == MODE_IDLE))
		else $error("text end did not return scan state to start");

	a_open_token_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (cnt_q != '0))
		else $error("open token with zero length");

	a_results_per_byte: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ($countones(cvld) <= MAX_RES))
		else $error("byte produced too many tokens");

endmodule

`default_nettype wire

>>> rtl/kot_rq.sv
// ----------------------------------------------------------------------------
// kot_rq
// result queue, takes up to four packed-down tokens a cycle, gives one while out_ready
// ----------------------------------------------------------------------------
`default_nettype none

module kot_rq import kot_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_en,
	input  cand_vec_t cands,
	output logic      space_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output tok_out_t  out_data
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	tok_out_t         mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] off [NCAND];
	logic [CNT_W-1:0] push_n;
	logic             pop;

	// slot offsets: valid candidates ahead of each one
	always_comb begin
		push_n = '0;
		for (int i = 0; i < NCAND; i++) begin
			off[i] = PTR_W'(push_n);
			if (cands[i].vld)
				push_n = push_n + CNT_W'(1);
		end
		if (!push_en)
			push_n = '0;
	end

	assign space_ok  = (cnt_q <= CNT_W'(Q_DEPTH - MAX_RES));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rp_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NCAND; i++) begin
			if (push_en && cands[i].vld)
				mem_q[wp_q + off[i]] <= cands[i].tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push_n);
			if (pop)
				rp_q <= rp_q + PTR_W'(1);
			cnt_q <= cnt_q + push_n - CNT_W'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cnt_q) + int'(push_n)) <= Q_DEPTH)
		else $error("result queue overrun");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(Q_DEPTH))
		else $error("result queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == '0) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("result queue count lost a pop");

endmodule

`default_nettype wire

>>> bench/keyword_operator_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// keyword_operator_tokenizer_tb
// self-checking bench for the streaming tokenizer
// ----------------------------------------------------------------------------
// Source bytes go in through the valid/ready source port, and the bench keeps
// its own lexer state to work out the tokens that each accepted byte must
// produce. Those tokens wait in a queue. Every token transaction on the output
// port is checked field by field against the oldest one. Directed texts cover
// all operators, keywords, byte-class boundaries, end-of-text forms and long
// tokens. A random part then sends well-formed token streams mixed with noise
// bytes. Both ports idle at random, with some steady stretches.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_operator_tokenizer_tb import kot_pkg::*;;

	localparam int LEN_CAP      = 63;
	localparam int RANDOM_ITEMS = 16;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 100_000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     src_valid;
	logic     src_ready;
	tok_in_t  src_data;
	logic     tok_valid;
	logic     tok_ready;
	tok_out_t tok_data;

	// bench lexer state
	scan_mode_t  lex_mode;
	logic [15:0] lex_start;
	logic [15:0] lex_pos;
	logic [5:0]  lex_count;
	logic        lex_ovf;
	logic [63:0] lex_name;

	tok_out_t byte_tokens[$];
	tok_out_t expected_tokens[$];

	string keyword_text[7] = '{"print", "if", "else", "end", "then", "function", "return"};

	bit steady = 1'b0;
	int mismatches = 0;
	int cycle_count = 0;

	keyword_operator_tokenizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	always #6 clk = ~clk;

	// run time limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// lexer model
	// ------------------------------------------------------------------------
	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// space plus tab through carriage return
	function automatic bit blank_char(logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [63:0] word_bits(string s);
		logic [63:0] r;
		int i;
		r = '0;
		for (i = 0; i < s.len() && i < 8; i++)
			r[8*i +: 8] = s[i];
		return r;
	endfunction

	function automatic void add_token(logic [4:0] tt, logic [15:0] st, logic [5:0] len,
			logic ovf);
		tok_out_t t;
		t = '{token_type: tt, start_pos: st, tok_len: len, too_long: ovf, run_end: 1'b0};
		byte_tokens.push_back(t);
	endfunction

	function automatic void grow_token(logic [7:0] c);
		// only the first eight bytes matter for keyword matching
		if (lex_count < 8)
			lex_name[8*lex_count +: 8] = c;
		if (lex_count < LEN_CAP)
			lex_count++;
		else
			lex_ovf = 1'b1;
	endfunction

	function automatic void open_token(scan_mode_t m, logic [7:0] c);
		lex_mode  = m;
		lex_start = lex_pos;
		lex_count = '0;
		lex_ovf   = 1'b0;
		lex_name  = '0;
		grow_token(c);
	endfunction

	function automatic logic [4:0] name_type();
		logic [4:0] t;
		int k;
		t = TT_NAME;
		if (!lex_ovf && lex_count <= 8) begin
			for (k = 0; k < 7; k++) begin
				if (keyword_text[k].len() == lex_count && word_bits(keyword_text[k]) == lex_name)
					t = 5'(TT_PRINT + k);
			end
		end
		return t;
	endfunction

	function automatic logic [4:0] single_op(logic [7:0] c);
		case (c)
			"+": return TT_PLUS;
			"-": return TT_MINUS;
			"*": return TT_STAR;
			"/": return TT_SLASH;
			"(": return TT_LPAREN;
			")": return TT_RPAREN;
			">": return TT_GT;
			"<": return TT_LT;
			default: return TT_UNKNOWN;
		endcase
	endfunction

	// emit whatever token is still open
	function automatic void close_token();
		case (lex_mode)
			MODE_NUM:  add_token(TT_NUM, lex_start, lex_count, lex_ovf);
			MODE_NAME: add_token(name_type(), lex_start, lex_count, lex_ovf);
			MODE_EQ:   add_token(TT_ASSIGN, lex_start, 6'd1, 1'b0);
			MODE_BANG: add_token(TT_UNKNOWN, lex_start, 6'd1, 1'b0);
			default: begin
			end
		endcase
		lex_mode = MODE_IDLE;
	endfunction

	function automatic void clear_lexer();
		lex_mode  = MODE_IDLE;
		lex_start = '0;
		lex_pos   = '0;
		lex_count = '0;
		lex_ovf   = 1'b0;
		lex_name  = '0;
	endfunction

	// tokens caused by one accepted byte, appended to the expected queue
	function automatic void tokenize_byte(logic [7:0] c, logic fin);
		bit used;
		bit ended;
		int i;
		tok_out_t t;
		used  = 1'b0;
		ended = 1'b0;
		byte_tokens.delete();
		if (lex_mode == MODE_NUM && digit_char(c)) begin
			grow_token(c);
			used = 1'b1;
		end else if (lex_mode == MODE_NAME && (letter_char(c) || digit_char(c))) begin
			grow_token(c);
			used = 1'b1;
		end else if ((lex_mode == MODE_EQ || lex_mode == MODE_BANG) && c == CH_EQ) begin
			add_token((lex_mode == MODE_EQ) ? TT_EQEQ : TT_NE, lex_start, 6'd2, 1'b0);
			lex_mode = MODE_IDLE;
			used = 1'b1;
		end else begin
			close_token();
		end

		if (!used) begin
			if (c == CH_NUL) begin
				add_token(TT_EOF, lex_pos, 6'd0, 1'b0);
				ended = 1'b1;
			end else if (blank_char(c)) begin
				// separators produce nothing
			end else if (digit_char(c)) begin
				open_token(MODE_NUM, c);
			end else if (letter_char(c)) begin
				open_token(MODE_NAME, c);
			end else if (c == CH_EQ) begin
				open_token(MODE_EQ, c);
			end else if (c == CH_BANG) begin
				open_token(MODE_BANG, c);
			end else begin
				add_token(single_op(c), lex_pos, 6'd1, 1'b0);
			end
		end

		// a final byte closes the open token, eof sits just past it
		if (!ended) begin
			lex_pos++;
			if (fin) begin
				close_token();
				add_token(TT_EOF, lex_pos, 6'd0, 1'b0);
				ended = 1'b1;
			end
		end
		if (ended)
			clear_lexer();

		for (i = 0; i < byte_tokens.size(); i++) begin
			t = byte_tokens[i];
			t.run_end = (i == byte_tokens.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	function automatic void note_error(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	function automatic void check_token(tok_out_t got);
		tok_out_t want;
		if (expected_tokens.size() == 0) begin
			note_error($sformatf("unexpected token: type %0d start %0d len %0d long %0b last %0b",
				got.token_type, got.start_pos, got.tok_len, got.too_long, got.run_end));
		end else begin
			want = expected_tokens.pop_front();
			if (got.token_type !== want.token_type || got.start_pos !== want.start_pos ||
					got.tok_len !== want.tok_len || got.too_long !== want.too_long ||
					got.run_end !== want.run_end)
				note_error($sformatf({"token mismatch: expected type %0d start %0d len %0d ",
					"long %0b last %0b, got type %0d start %0d len %0d long %0b last %0b"},
					want.token_type, want.start_pos, want.tok_len, want.too_long,
					want.run_end, got.token_type, got.start_pos, got.tok_len,
					got.too_long, got.run_end));
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready)
			check_token(tok_data);
	end

	// token sink: random stall before each transaction
	initial begin : token_sink
		int stall;
		tok_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (stall > 0) begin
				tok_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tok_ready <= 1'b1;
			do @(posedge clk); while (!tok_valid);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_data  <= '{ch: c, is_final: fin};
		src_valid <= 1'b1;
		do @(posedge clk); while (!src_ready);
		tokenize_byte(c, fin);
	endtask

	task automatic send_text(input string s, input bit fin_last);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], fin_last && i == s.len() - 1);
	endtask

	task automatic test_operators();
		send_text("+-*/()><=a==b!=c= =", 1'b0);
		send_byte(CH_NUL, 1'b0);
	endtask

	task automatic test_keywords();
		send_text("print if\telse end then function return", 1'b1);
	endtask

	task automatic test_edge_cases();
		int c;
		// lone bang, number running into a name, near-keyword
		send_text("!x 12ab Print ", 1'b0);
		// neighbors of the digit and letter ranges
		send_text("/09:@AZ[`az{", 1'b0);
		for (c = 8; c <= 14; c++)
			send_byte(8'(c), 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(CH_NUL, 1'b0);
		// pending '=', then an operator that is also final: three tokens
		send_byte(CH_EQ, 1'b0);
		send_byte("+", 1'b1);
		// lone bang, then a second bang closed by the end of text
		send_byte(CH_BANG, 1'b0);
		send_byte(CH_BANG, 1'b1);
		send_byte(CH_BANG, 1'b0);
		send_byte(CH_EQ, 1'b1);
		send_text("x7", 1'b1);
		send_byte(CH_NUL, 1'b1);
		send_byte(" ", 1'b1);
	endtask

	task automatic test_long_tokens();
		int i;
		// one byte past the cap, closed by an operator
		for (i = 0; i < 64; i++)
			send_byte((i % 4 == 3) ? 8'("0" + i % 10) : 8'("A" + i % 26), 1'b0);
		send_byte("+", 1'b0);
	endtask

	function automatic string random_word();
		string s;
		int i;
		int n;
		logic [7:0] c;
		s = "";
		case ($urandom_range(0, 5))
			0: s = keyword_text[$urandom_range(0, 6)];
			1: begin
				n = $urandom_range(1, 10);
				for (i = 0; i < n; i++) begin
					if (i > 0 && $urandom_range(0, 2) == 0)
						c = 8'($urandom_range("0", "9"));
					else if ($urandom_range(0, 1))
						c = 8'($urandom_range("a", "z"));
					else
						c = 8'($urandom_range("A", "Z"));
					s = $sformatf("%s%c", s, c);
				end
			end
			2: begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					s = $sformatf("%s%c", s, 8'($urandom_range("0", "9")));
			end
			3: begin
				case ($urandom_range(0, 11))
					0: s = "+";
					1: s = "-";
					2: s = "*";
					3: s = "/";
					4: s = "(";
					5: s = ")";
					6: s = "<";
					7: s = ">";
					8: s = "=";
					9: s = "==";
					10: s = "!=";
					default: s = "!";
				endcase
			end
			// keyword with one byte too many, or cut short
			4: begin
				s = keyword_text[$urandom_range(0, 6)];
				if ($urandom_range(0, 1))
					s = $sformatf("%s%c", s, 8'($urandom_range("a", "z")));
				else
					s = s.substr(0, s.len() - 2);
			end
			default: s = $sformatf("%0d%s", $urandom_range(0, 999),
				keyword_text[$urandom_range(0, 6)]);
		endcase
		return s;
	endfunction

	task automatic test_random_text();
		int sent;
		int pieces;
		int end_kind;
		string piece;
		sent = 0;
		pieces = 0;
		while (sent < RANDOM_ITEMS) begin
			if (pieces % 8 == 0)
				steady = ($urandom_range(0, 3) == 0);
			pieces++;
			if ($urandom_range(0, 9) < 7) begin
				piece = random_word();
				end_kind = $urandom_range(0, 11);
				send_text(piece, end_kind == 1);
				sent += piece.len();
				if (end_kind == 0)
					send_byte(CH_NUL, 1'($urandom_range(0, 1)));
				else if (end_kind > 1 && $urandom_range(0, 1))
					send_byte(8'($urandom_range(0, 1) ? " " : $urandom_range(9, 13)), 1'b0);
			end else begin
				// noise byte, now and then the final one
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_data  = '0;
		clear_lexer();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_operators();
		test_keywords();
		test_edge_cases();
		test_long_tokens();
		test_random_text();

		@(negedge clk);
		src_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0)
			note_error($sformatf("%0d tokens never arrived", expected_tokens.size()));

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
